@@ rtl/bb3_pkg.sv @@
// Shared types, constants and the reciprocal table for the 3x3 box blur.
// No dependencies; every other file of the block but bb3_ram imports this package.

package bb3_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	localparam int PIX_W     = 8;
	localparam int CHAN_N    = 3;
	localparam int DIM_W     = 11;
	localparam int CFG_IDX_W = 2;

	localparam int FRAME_WIDTH_RST  = 640;
	localparam int FRAME_HEIGHT_RST = 480;

	// neighbourhood sum, rounded numerator 2*sum+count, reciprocal scale
	localparam int SUM_W  = 12;
	localparam int NUM_W  = 13;
	localparam int CNT_W  = 4;
	localparam int RCP_W  = 18;
	localparam int RCP_SH = 18;
	localparam int PROD_W = NUM_W + RCP_W;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 2'd0,
		CFG_FRAME_HEIGHT = 2'd1
	} bb3_cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_SUM,
		ST_SCALE
	} bb3_state_t;

	// [2] red, [1] green, [0] blue
	typedef logic [CHAN_N-1:0][PIX_W-1:0] bb3_rgb_t;

	typedef struct packed {
		logic take;
		logic shift;
		logic sum;
		logic load;
	} bb3_cmd_t;

	typedef struct packed {
		logic drop;
		logic has_out;
		logic out_free;
		logic last_out;
		logic at_origin;
	} bb3_sts_t;

	// ceil(2^18 / (2*count)); exact floor division for numerators below 2^13
	function automatic logic [RCP_W-1:0] bb3_recip(input logic [CNT_W-1:0] count);
		logic [RCP_W-1:0] r;
		case (count)
			4'd1:    r = 18'd131072;
			4'd2:    r = 18'd65536;
			4'd3:    r = 18'd43691;
			4'd4:    r = 18'd32768;
			4'd6:    r = 18'd21846;
			4'd9:    r = 18'd14564;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/bb3_if.sv @@
// Handshake channels of the box blur: pixel requests, blurred results and
// configuration writes. Depends on bb3_pkg.

interface bb3_in_if import bb3_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             req_type;
	logic [PIX_W-1:0] red;
	logic [PIX_W-1:0] green;
	logic [PIX_W-1:0] blue;

	modport source (output valid, req_type, red, green, blue, input ready);
	modport sink   (input valid, req_type, red, green, blue, output ready);
endinterface

interface bb3_out_if import bb3_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] blur_red;
	logic [PIX_W-1:0] blur_green;
	logic [PIX_W-1:0] blur_blue;
	logic             frame_end;

	modport source (output valid, blur_red, blur_green, blur_blue, frame_end, input ready);
	modport sink   (input valid, blur_red, blur_green, blur_blue, frame_end, output ready);
endinterface

interface bb3_cfg_if import bb3_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DIM_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/box_blur_3x3_edge_normalized.sv @@
// 3x3 box blur over an RGB raster stream; each result is the per-channel
// average of the in-frame neighbours, rounded half up. A request without a
// result passes line-store read and window shift, one with a result also
// neighbourhood sum and reciprocal scale, waiting while the sink still holds
// the output register; the input is ready again once the request is through.
// Results lag the input by one row and one pixel: after the last pixel of a
// frame send frame_width + 1 drain requests. A drain while pixels are still
// due is discarded and leaves the input ready; a pixel sent after the frame's
// last pixel counts as a drain. Width and height of 0 act as 1, larger than
// MAX_WIDTH/MAX_HEIGHT act as the maximum; a write to either frame register
// restarts the frame. The line stores need no clearing after reset. Depends
// on bb3_pkg, bb3_if, bb3_ctrl and bb3_datapath.

module box_blur_3x3_edge_normalized import bb3_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input logic        clk,
	input logic        arst_n,
	bb3_in_if.sink     pixel,
	bb3_out_if.source  blur,
	bb3_cfg_if.sink    cfg
);

	bb3_cmd_t cmd;
	bb3_sts_t sts;
	logic     in_ready;

	assign cfg.ready   = 1'b1;
	assign pixel.ready = in_ready;

	bb3_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixel.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bb3_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req_type   (pixel.req_type),
		.red        (pixel.red),
		.green      (pixel.green),
		.blue       (pixel.blue),
		.cfg_we     (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.out_valid  (blur.valid),
		.out_ready  (blur.ready),
		.blur_red   (blur.blur_red),
		.blur_green (blur.blur_green),
		.blur_blue  (blur.blur_blue),
		.frame_end  (blur.frame_end)
	);

	// window shift always uses the line-store data read in the cycle before
	a_shift_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |-> $past(cmd.take))
		else $error("window shift without a preceding line-store read");

	// the frame's last result leaves every position counter at the origin
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && sts.last_out |=> sts.at_origin)
		else $error("counters not cleared after the last result of a frame");

	// a swallowed drain request keeps the block ready for the next request
	a_drop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid && pixel.ready && sts.drop |=> pixel.ready)
		else $error("ignored drain request left the block busy");

endmodule

@@ rtl/bb3_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module bb3_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/bb3_ctrl.sv @@
// Sequencer of the box blur: read and shift for each taken request, then sum and scale if it has a result.
// Depends on bb3_pkg; drives the datapath through bb3_cmd_t.

module bb3_ctrl import bb3_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  bb3_sts_t sts,
	output bb3_cmd_t cmd
);

	bb3_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && !sts.drop) begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				state_d = sts.has_out ? ST_SUM : ST_IDLE;
			end
			ST_SUM: begin
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid && !sts.drop;
			end
			ST_SHIFT: cmd.shift = 1'b1;
			ST_SUM:   cmd.sum   = 1'b1;
			ST_SCALE: cmd.load  = sts.out_free;
			default: ;
		endcase
	end

endmodule

@@ rtl/bb3_datapath.sv @@
// Line stores, 3x3 window, position counters, neighbourhood sums and the
// reciprocal scaling with the output register. Depends on bb3_pkg, bb3_ram.

module bb3_datapath import bb3_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bb3_cmd_t             cmd,
	output bb3_sts_t             sts,
	input  logic                 req_type,
	input  logic [PIX_W-1:0]     red,
	input  logic [PIX_W-1:0]     green,
	input  logic [PIX_W-1:0]     blue,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [PIX_W-1:0]     blur_red,
	output logic [PIX_W-1:0]     blur_green,
	output logic [PIX_W-1:0]     blur_blue,
	output logic                 frame_end
);

	localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int ORW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	// input row runs one past the frame while the last outputs drain
	localparam int RW  = $clog2(MAX_HEIGHT + 2);
	localparam int RGB_W = $bits(bb3_rgb_t);

	localparam logic [WW-1:0] W_RST =
		WW'(FRAME_WIDTH_RST > MAX_WIDTH ? MAX_WIDTH : FRAME_WIDTH_RST);
	localparam logic [HW-1:0] H_RST =
		HW'(FRAME_HEIGHT_RST > MAX_HEIGHT ? MAX_HEIGHT : FRAME_HEIGHT_RST);

	function automatic logic [WW-1:0] clamp_w(input logic [DIM_W-1:0] v);
		logic [WW-1:0] r;
		if (v == '0) begin
			r = WW'(1);
		end else if (int'(v) > MAX_WIDTH) begin
			r = WW'(MAX_WIDTH);
		end else begin
			r = WW'(v);
		end
		return r;
	endfunction

	function automatic logic [HW-1:0] clamp_h(input logic [DIM_W-1:0] v);
		logic [HW-1:0] r;
		if (v == '0) begin
			r = HW'(1);
		end else if (int'(v) > MAX_HEIGHT) begin
			r = HW'(MAX_HEIGHT);
		end else begin
			r = HW'(v);
		end
		return r;
	endfunction

	logic [WW-1:0]  w_q;
	logic [HW-1:0]  h_q;
	logic [WW-1:0]  w_m1;
	logic [HW-1:0]  h_m1;
	logic [RW-1:0]  in_row_q;
	logic [CW-1:0]  in_col_q;
	logic [ORW-1:0] out_row_q;
	logic [CW-1:0]  out_col_q;

	logic           real_q;
	bb3_rgb_t       px_q;
	bb3_rgb_t       win_q [9];
	bb3_rgb_t       up_rd;
	bb3_rgb_t       lo_rd;
	bb3_rgb_t       new_col [3];

	logic           pixels_due;
	logic           in_col_last;
	logic           row_last;
	logic           col_last;
	logic           cfg_hit;
	logic [2:0]     row_ok;
	logic [2:0]     col_ok;
	logic [1:0]     nr;
	logic [1:0]     nc;
	logic [CNT_W-1:0] count_d;
	logic [CNT_W-1:0] count_q;
	logic [CHAN_N-1:0][SUM_W-1:0] sum_d;
	logic [CHAN_N-1:0][SUM_W-1:0] sum_q;
	logic [CHAN_N-1:0][SUM_W-1:0] row_sum [3];
	logic [CHAN_N-1:0][NUM_W-1:0] numer;
	logic [CHAN_N-1:0][PROD_W-1:0] prod;
	logic [RCP_W-1:0] rcp;

	logic           out_valid_q;
	bb3_rgb_t       out_pix_q;
	logic           out_end_q;

	// ---------------------------------------------------------------
	// frame geometry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= W_RST;
			h_q <= H_RST;
		end else if (cfg_we) begin
			unique case (bb3_cfg_idx_t'(cfg_index))
				CFG_FRAME_WIDTH:  w_q <= clamp_w(cfg_data);
				CFG_FRAME_HEIGHT: h_q <= clamp_h(cfg_data);
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg_hit = 1'b0;
		unique case (bb3_cfg_idx_t'(cfg_index))
			CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT: cfg_hit = cfg_we;
			default: cfg_hit = 1'b0;
		endcase
	end

	assign w_m1        = w_q - 1'b1;
	assign h_m1        = h_q - 1'b1;
	assign pixels_due  = in_row_q < RW'(h_q);
	assign in_col_last = WW'(in_col_q) == w_m1;
	assign row_last    = HW'(out_row_q) == h_m1;
	assign col_last    = WW'(out_col_q) == w_m1;

	// ---------------------------------------------------------------
	// position counters; a frame-register write or the frame's last result restarts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (cfg_hit || (cmd.load && row_last && col_last)) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else begin
			if (cmd.shift) begin
				if (in_col_last) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
			if (cmd.load) begin
				if (col_last) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + 1'b1;
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// request latch and line stores
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			real_q <= 1'b0;
		end else if (cmd.take) begin
			real_q <= pixels_due && (req_type == REQ_PIXEL);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			px_q <= {red, green, blue};
		end
	end

	bb3_ram #(.WIDTH(RGB_W), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (cmd.shift && real_q),
		.waddr (in_col_q),
		.wdata (lo_rd),
		.re    (cmd.take),
		.raddr (in_col_q),
		.rdata (up_rd)
	);

	bb3_ram #(.WIDTH(RGB_W), .DEPTH(MAX_WIDTH)) u_lower (
		.clk   (clk),
		.we    (cmd.shift && real_q),
		.waddr (in_col_q),
		.wdata (px_q),
		.re    (cmd.take),
		.raddr (in_col_q),
		.rdata (lo_rd)
	);

	// ---------------------------------------------------------------
	// 3x3 window, row 0 oldest, column 2 newest
	assign new_col[0] = up_rd;
	assign new_col[1] = lo_rd;
	assign new_col[2] = real_q ? px_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (cmd.shift) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r*3]     <= win_q[r*3 + 1];
				win_q[r*3 + 1] <= win_q[r*3 + 2];
				win_q[r*3 + 2] <= new_col[r];
			end
		end
	end

	// ---------------------------------------------------------------
	// in-frame neighbourhood sum and cell count
	assign row_ok = {~row_last, 1'b1, out_row_q != '0};
	assign col_ok = {~col_last, 1'b1, out_col_q != '0};
	assign nr     = 2'(1) + 2'(row_ok[0]) + 2'(row_ok[2]);
	assign nc     = 2'(1) + 2'(col_ok[0]) + 2'(col_ok[2]);
	assign count_d = CNT_W'(nr) * CNT_W'(nc);

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < CHAN_N; k++) begin
				row_sum[r][k] = '0;
				for (int c = 0; c < 3; c++) begin
					if (row_ok[r] && col_ok[c]) begin
						row_sum[r][k] = row_sum[r][k] + SUM_W'(win_q[r*3 + c][k]);
					end
				end
			end
		end
		for (int k = 0; k < CHAN_N; k++) begin
			sum_d[k] = row_sum[0][k] + row_sum[1][k] + row_sum[2][k];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			sum_q   <= sum_d;
			count_q <= count_d;
		end
	end

	// ---------------------------------------------------------------
	// (2*sum+count)/(2*count) as a multiply by the rounded-up reciprocal
	assign rcp = bb3_recip(count_q);

	always_comb begin
		for (int k = 0; k < CHAN_N; k++) begin
			numer[k] = {sum_q[k], 1'b0} + NUM_W'(count_q);
			prod[k]  = PROD_W'(numer[k]) * PROD_W'(rcp);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int k = 0; k < CHAN_N; k++) begin
				out_pix_q[k] <= prod[k][RCP_SH +: PIX_W];
			end
			out_end_q <= row_last && col_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign blur_red   = out_pix_q[2];
	assign blur_green = out_pix_q[1];
	assign blur_blue  = out_pix_q[0];
	assign frame_end  = out_end_q;

	// ---------------------------------------------------------------
	assign sts.drop      = pixels_due && (req_type == REQ_DRAIN);
	assign sts.has_out   = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (in_col_q != '0));
	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.last_out  = row_last && col_last;
	assign sts.at_origin = (in_row_q == '0) && (in_col_q == '0) &&
		(out_row_q == '0) && (out_col_q == '0);

endmodule
